/* src/mcma_pkg.sv */
// Package for the multichannel moving-average block: default sizes, port
// field widths, the result record and the sequencer state type.
// No dependencies.
package mcma_pkg;

  // Default sizes, used as parameter defaults on the top level.
  localparam int unsigned ChannelsDef   = 128;
  localparam int unsigned WindowDef     = 5;
  localparam int unsigned SampleBitsDef = 16;

  // Fixed field widths of the stream ports.
  localparam int unsigned ChW       = 7;
  localparam int unsigned SmpW      = 16;
  localparam int unsigned AvgW      = 16;
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 24;

  // Result queue depth and the width of counters that can hold it.
  localparam int unsigned OutqDepth = 8;
  localparam int unsigned OutqPtrW  = $clog2(OutqDepth);
  localparam int unsigned OutqCntW  = $clog2(OutqDepth + 1);

  // One result beat, channel in the low bits.
  typedef struct packed {
    logic [AvgW-1:0] average;
    logic [ChW-1:0]  channel;
  } mcma_res_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } mcma_state_e;

endpackage

/* src/mcma_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mcma_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/mcma_outq.sv */
// Small result queue in front of the master stream port.
// Depends on mcma_pkg for the result record and the queue depth.
module mcma_outq import mcma_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mcma_res_t push_data_i,
  output logic      valid_o,
  output mcma_res_t data_o,
  input  logic      pop_i
);

  mcma_res_t             ent_q [OutqDepth];
  logic [OutqPtrW-1:0]   wptr_q, wptr_d;
  logic [OutqPtrW-1:0]   rptr_q, rptr_d;
  logic [OutqCntW-1:0]   cnt_q, cnt_d;
  logic                  do_pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = ent_q[rptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* src/multichannel_moving_average_top.sv */
// Top level of the multichannel moving-average filter.
// Depends on mcma_pkg, mcma_ram and mcma_outq.
//
//  Port group  Dir  tdata fields (lowest bit first)         Beat meaning
//  s_axis      in   channel[6:0], sample[22:7], pad[23]      one new sample
//  m_axis      out  channel[6:0], average[22:7], pad[23]     one filtered value
//
// One beat in gives exactly one beat out, in order, by way of stages 1 to 3
// and the result queue. Samples are accepted one per cycle while s_axis_tready
// is high; the limit is the single read-modify-write of the per-channel row
// RAM, which handles one channel per cycle with forwarding for the same channel
// on consecutive beats. After reset the block clears the row RAM, one row a
// cycle, with s_axis_tready low. A credit counter keeps the number of beats
// in flight within the result queue, so a stall on m_axis only stops input
// once as many beats are in flight as that queue holds; the pipeline itself
// never stops.
module multichannel_moving_average_top import mcma_pkg::*; #(
  parameter int unsigned CHANNELS    = ChannelsDef,
  parameter int unsigned WINDOW      = WindowDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // channel [6:0], sample [22:7], zero [23]
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // channel [6:0], average [22:7], zero [23]
  output logic [OutTdataW-1:0] m_axis_tdata
);

  // Each RAM row holds one channel: the window (oldest sample in the lowest
  // bits) with the running window sum above it.
  localparam int unsigned AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int unsigned WIN_W  = WINDOW * SAMPLE_BITS;
  localparam int unsigned ROW_W  = SUM_W + WIN_W;
  // Division by WINDOW is a multiply by a rounded-up reciprocal; with this
  // shift the quotient is exact for every sum that fits SUM_W bits.
  localparam int unsigned SH     = SUM_W + $clog2(WINDOW);
  localparam longint unsigned RECIP_L =
    ((longint'(1) << SH) + longint'(WINDOW) - 1) / longint'(WINDOW);
  localparam int unsigned PROD_W = SUM_W + SH + 1;

  // Sequencer: clearing pass, then normal operation.
  mcma_state_e   state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          clr_we;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    clr_we  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == AW'(CHANNELS - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        clr_d = clr_q;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Input side and credits for the result queue.
  logic [ChW-1:0]         in_ch;
  logic [SAMPLE_BITS-1:0] in_smp;
  logic                   in_acc;
  logic                   in_inr;
  logic                   out_pop;
  logic [OutqCntW-1:0]    cred_q, cred_d;

  assign in_ch         = s_axis_tdata[ChW-1:0];
  assign in_smp        = SAMPLE_BITS'(s_axis_tdata[ChW+SmpW-1:ChW]);
  assign in_inr        = (32'(in_ch) < CHANNELS);
  assign s_axis_tready = (state_q == ST_RUN) && (cred_q < OutqCntW'(OutqDepth));
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_pop       = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cred_d = cred_q;
    if (in_acc && !out_pop) begin
      cred_d = cred_q + 1'b1;
    end else if (!in_acc && out_pop) begin
      cred_d = cred_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= '0;
    end else begin
      cred_q <= cred_d;
    end
  end

  // Stage 1: row read returns; update the window and the running sum.
  logic                   s1_vld_q, s1_inr_q;
  logic [ChW-1:0]         s1_ch_q;
  logic [SAMPLE_BITS-1:0] s1_smp_q;
  logic [ROW_W-1:0]       ram_rdata;
  logic [ROW_W-1:0]       cur_row;
  logic [ROW_W-1:0]       new_row;
  logic [WIN_W-1:0]       cur_win, new_win;
  logic [SUM_W-1:0]       cur_sum, new_sum;
  logic [SAMPLE_BITS-1:0] oldest;
  logic                   s1_we;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [ROW_W-1:0]       ram_wdata;

  // Last row written, kept to cover a read that raced with that write.
  logic                   wb_vld_q;
  logic [ChW-1:0]         wb_ch_q;
  logic [ROW_W-1:0]       wb_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      wb_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_acc;
      wb_vld_q <= s1_we;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ch_q  <= in_ch;
    s1_smp_q <= in_smp;
    s1_inr_q <= in_inr;
    wb_ch_q  <= s1_ch_q;
    wb_row_q <= new_row;
  end

  assign cur_row = (wb_vld_q && (wb_ch_q == s1_ch_q)) ? wb_row_q : ram_rdata;
  assign cur_win = cur_row[WIN_W-1:0];
  assign cur_sum = cur_row[ROW_W-1:WIN_W];
  assign oldest  = cur_win[SAMPLE_BITS-1:0];
  assign new_sum = cur_sum - SUM_W'(oldest) + SUM_W'(s1_smp_q);
  assign new_row = {new_sum, new_win};
  assign s1_we   = s1_vld_q && s1_inr_q;

  if (WINDOW == 1) begin : g_win_one
    assign new_win = s1_smp_q;
  end else begin : g_win_shift
    assign new_win = {s1_smp_q, cur_win[WIN_W-1:SAMPLE_BITS]};
  end

  assign ram_we    = clr_we || s1_we;
  assign ram_waddr = clr_we ? clr_q : AW'(s1_ch_q);
  assign ram_wdata = clr_we ? '0 : new_row;

  mcma_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CHANNELS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc && in_inr),
    .raddr_i (AW'(in_ch)),
    .rdata_o (ram_rdata)
  );

  // Stage 2: multiply the sum by the reciprocal. Out-of-range channels carry
  // a zero sum, which gives a zero average.
  logic             s2_vld_q;
  logic [ChW-1:0]   s2_ch_q;
  logic [SUM_W-1:0] s2_sum_q;
  logic [SH:0]      recip;

  assign recip = RECIP_L[SH:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_ch_q  <= s1_ch_q;
    s2_sum_q <= s1_inr_q ? new_sum : '0;
  end

  // Stage 3: product registered, quotient taken by shift.
  logic              s3_vld_q;
  logic [ChW-1:0]    s3_ch_q;
  logic [PROD_W-1:0] s3_prod_q;
  mcma_res_t         s3_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_ch_q   <= s2_ch_q;
    s3_prod_q <= PROD_W'(s2_sum_q) * PROD_W'(recip);
  end

  assign s3_res.channel = s3_ch_q;
  assign s3_res.average = AvgW'(s3_prod_q[PROD_W-1:SH]);

  // Result queue toward the master port.
  mcma_res_t out_res;

  mcma_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_vld_q),
    .push_data_i (s3_res),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_res),
    .pop_i       (m_axis_tready)
  );

  assign m_axis_tdata = OutTdataW'(out_res);

  // The clearing pass and item traffic never share the RAM write port.
  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready && !s1_vld_q)
    else $error("item in flight during the clearing pass");

  // Beats in flight never exceed the result queue depth.
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cred_q <= OutqCntW'(OutqDepth))
    else $error("credit counter above result queue depth");

  // An accepted beat always reaches the result queue by way of stages 1, 2 and 3.
  a_pipe_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##3 s3_vld_q)
    else $error("accepted beat lost in the pipeline");

endmodule
